>>> rtl/core/binary_trie_prefix_table_assert.svh
// Assertion macros for the binary trie prefix table.
`ifndef BINARY_TRIE_PREFIX_TABLE_ASSERT_SVH
`define BINARY_TRIE_PREFIX_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BTPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define BTPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BTPT_ASSERT_IMP(lbl, ante, cons, msg)
`define BTPT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/btpt_pkg.sv
// Shared types and constants for the binary trie prefix table.
`timescale 1ns / 1ps
package btpt_pkg;
    localparam int KEY_W   = 64;
    localparam int PLEN_W  = 7;
    localparam int VALIN_W = 32;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 40;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_NF    = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_FETCH    = 4'd2;
    localparam logic [3:0] OP_DESCEND  = 4'd3;
    localparam logic [3:0] OP_STATUS   = 4'd4;
    localparam logic [3:0] OP_FIN      = 4'd5;
    localparam logic [3:0] OP_SETVAL   = 4'd6;
    localparam logic [3:0] OP_CLRVAL   = 4'd7;
    localparam logic [3:0] OP_FREE_RD  = 4'd8;
    localparam logic [3:0] OP_TAKE_FR  = 4'd9;
    localparam logic [3:0] OP_TAKE_BMP = 4'd10;
    localparam logic [3:0] OP_WR_NEW   = 4'd11;
    localparam logic [3:0] OP_LINK     = 4'd12;
    localparam logic [3:0] OP_FREE     = 4'd13;
    localparam logic [3:0] OP_UNLINK   = 4'd14;
    localparam logic [3:0] OP_OUT      = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] code;
        logic       latch;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       at_plen;
        logic       last_step;
        logic       at_key_end;
        logic       child_zero;
        logic       cur_valid;
        logic       has_child;
        logic       node_zero;
        logic       free_nz;
        logic       bump_ok;
        logic       prune_stop;
        logic       out_free;
    } stat_t;
endpackage

>>> rtl/core/btpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module btpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/core/btpt_ctrl.sv
// Request sequencer for the binary trie prefix table.
`timescale 1ns / 1ps
module btpt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  btpt_pkg::stat_t   stat,
    output btpt_pkg::cmd_t    cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FETCH  = 4'd1;
    localparam logic [3:0] S_LOOK   = 4'd2;
    localparam logic [3:0] S_ALLOC  = 4'd3;
    localparam logic [3:0] S_TAKEF  = 4'd4;
    localparam logic [3:0] S_WNEW   = 4'd5;
    localparam logic [3:0] S_LINK   = 4'd6;
    localparam logic [3:0] S_SETVAL = 4'd7;
    localparam logic [3:0] S_FREE   = 4'd8;
    localparam logic [3:0] S_UNLINK = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       prune_reg, prune_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            prune_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            prune_reg <= prune_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        prune_next = prune_reg;
        cmd.op     = btpt_pkg::OP_NONE;
        cmd.code   = btpt_pkg::ST_OK;
        cmd.latch  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = btpt_pkg::OP_LOAD;
                    prune_next = 1'b0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                cmd.op     = btpt_pkg::OP_FETCH;
                state_next = prune_reg ? S_UNLINK : S_LOOK;
            end
            S_LOOK: begin
                cmd.latch = 1'b1;
                case (stat.req)
                    btpt_pkg::REQ_LOOKUP: begin
                        if (stat.at_key_end || stat.child_zero) begin
                            cmd.op     = btpt_pkg::OP_FIN;
                            state_next = S_DONE;
                        end else begin
                            cmd.op     = btpt_pkg::OP_DESCEND;
                            state_next = S_FETCH;
                        end
                    end
                    btpt_pkg::REQ_INSERT: begin
                        if (!stat.at_plen) begin
                            if (stat.child_zero) begin
                                state_next = S_ALLOC;
                            end else begin
                                cmd.op     = btpt_pkg::OP_DESCEND;
                                state_next = S_FETCH;
                            end
                        end else if (stat.cur_valid) begin
                            cmd.op     = btpt_pkg::OP_STATUS;
                            cmd.code   = btpt_pkg::ST_DUP;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_SETVAL;
                        end
                    end
                    btpt_pkg::REQ_DELETE: begin
                        if (!stat.at_plen) begin
                            if (stat.child_zero) begin
                                cmd.op     = btpt_pkg::OP_STATUS;
                                cmd.code   = btpt_pkg::ST_NF;
                                state_next = S_DONE;
                            end else begin
                                cmd.op     = btpt_pkg::OP_DESCEND;
                                state_next = S_FETCH;
                            end
                        end else if (stat.has_child || stat.node_zero) begin
                            state_next = S_DONE;
                            if (stat.cur_valid) begin
                                cmd.op = btpt_pkg::OP_CLRVAL;
                            end else begin
                                cmd.op   = btpt_pkg::OP_STATUS;
                                cmd.code = btpt_pkg::ST_NF;
                            end
                        end else begin
                            // leaf: free it and prune upward
                            cmd.op     = btpt_pkg::OP_STATUS;
                            cmd.code   = btpt_pkg::ST_OK;
                            prune_next = 1'b1;
                            state_next = S_FREE;
                        end
                    end
                    default: begin
                        cmd.op     = btpt_pkg::OP_STATUS;
                        cmd.code   = btpt_pkg::ST_NF;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ALLOC: begin
                if (stat.free_nz) begin
                    cmd.op     = btpt_pkg::OP_FREE_RD;
                    state_next = S_TAKEF;
                end else if (stat.bump_ok) begin
                    cmd.op     = btpt_pkg::OP_TAKE_BMP;
                    state_next = S_WNEW;
                end else begin
                    cmd.op     = btpt_pkg::OP_STATUS;
                    cmd.code   = btpt_pkg::ST_FULL;
                    state_next = S_DONE;
                end
            end
            S_TAKEF: begin
                cmd.op     = btpt_pkg::OP_TAKE_FR;
                state_next = S_WNEW;
            end
            S_WNEW: begin
                cmd.op     = btpt_pkg::OP_WR_NEW;
                state_next = S_LINK;
            end
            S_LINK: begin
                cmd.op     = btpt_pkg::OP_LINK;
                state_next = stat.last_step ? S_SETVAL : S_ALLOC;
            end
            S_SETVAL: begin
                cmd.op     = btpt_pkg::OP_SETVAL;
                state_next = S_DONE;
            end
            S_FREE: begin
                cmd.op     = btpt_pkg::OP_FREE;
                state_next = S_FETCH;
            end
            S_UNLINK: begin
                cmd.latch  = 1'b1;
                cmd.op     = btpt_pkg::OP_UNLINK;
                state_next = stat.prune_stop ? S_DONE : S_FREE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = btpt_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/core/btpt_dp.sv
// Datapath of the binary trie prefix table: node memories, free list, walk registers.
`timescale 1ns / 1ps
module btpt_dp #(
    parameter int NODE_COUNT = 1024,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  btpt_pkg::cmd_t                   cmd,
    output btpt_pkg::stat_t                  stat,
    input  logic [1:0]                       in_req,
    input  logic [btpt_pkg::KEY_W-1:0]       in_key,
    input  logic [btpt_pkg::PLEN_W-1:0]      in_plen,
    input  logic [btpt_pkg::VALIN_W-1:0]     in_val,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [1:0]                       m_status,
    output logic                             m_hit,
    output logic [btpt_pkg::VALIN_W-1:0]     m_value
);
    localparam int IW = $clog2(NODE_COUNT);
    localparam int VW = (VALUE_BITS < btpt_pkg::VALIN_W) ? VALUE_BITS : btpt_pkg::VALIN_W;
    localparam int LW = 3 * IW;
    localparam int PW = btpt_pkg::PLEN_W;

    // control state
    logic [IW-1:0]  root_left_reg, root_left_next;
    logic [IW-1:0]  root_right_reg, root_right_next;
    logic           root_valid_reg, root_valid_next;
    logic [IW-1:0]  free_head_reg, free_head_next;
    logic [IW:0]    next_unused_reg, next_unused_next;
    logic           m_tvalid_reg, m_tvalid_next;
    // payload
    logic [VW-1:0]  root_data_reg, root_data_next;
    logic [1:0]     req_reg, req_next;
    logic [btpt_pkg::KEY_W-1:0] key_reg, key_next;
    logic [PW-1:0]  plen_reg, plen_next;
    logic [PW-1:0]  i_reg, i_next;
    logic [VW-1:0]  val_reg, val_next;
    logic [IW-1:0]  node_reg, node_next;
    logic [IW-1:0]  prev_reg, prev_next;
    logic [IW-1:0]  alloc_reg, alloc_next;
    logic [IW-1:0]  cur_left_reg, cur_left_next;
    logic [IW-1:0]  cur_right_reg, cur_right_next;
    logic [IW-1:0]  cur_parent_reg, cur_parent_next;
    logic           cur_valid_reg, cur_valid_next;
    logic [1:0]     status_reg, status_next;
    logic           hit_reg, hit_next;
    logic [VW-1:0]  res_reg, res_next;
    logic [1:0]     m_status_reg, m_status_next;
    logic           m_hit_reg, m_hit_next;
    logic [VW-1:0]  m_value_reg, m_value_next;

    // memories
    logic           lk_we, vl_we;
    logic [IW-1:0]  lk_waddr, vl_waddr, rd_addr;
    logic [LW-1:0]  lk_wdata, lk_rdata;
    logic [VW:0]    vl_wdata, vl_rdata;

    btpt_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_links (
        .aclk(aclk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(rd_addr), .rdata(lk_rdata)
    );
    btpt_ram #(.WIDTH(VW + 1), .DEPTH(NODE_COUNT)) u_values (
        .aclk(aclk), .we(vl_we), .waddr(vl_waddr), .wdata(vl_wdata),
        .raddr(rd_addr), .rdata(vl_rdata)
    );

    logic           node_is_root;
    logic [IW-1:0]  f_left, f_right, f_parent;
    logic           f_valid;
    logic [VW-1:0]  f_data;
    logic [IW-1:0]  v_left, v_right, v_parent;
    logic           v_valid;
    logic [IW-1:0]  child;
    logic [IW-1:0]  u_left, u_right;
    logic [PW-1:0]  plen_clamped;

    // root lives in registers; other nodes come from the memories
    assign node_is_root = (node_reg == '0);
    assign f_left   = node_is_root ? root_left_reg  : lk_rdata[IW-1:0];
    assign f_right  = node_is_root ? root_right_reg : lk_rdata[2*IW-1:IW];
    assign f_parent = node_is_root ? '0             : lk_rdata[3*IW-1:2*IW];
    assign f_valid  = node_is_root ? root_valid_reg : vl_rdata[VW];
    assign f_data   = node_is_root ? root_data_reg  : vl_rdata[VW-1:0];

    assign v_left   = cmd.latch ? f_left   : cur_left_reg;
    assign v_right  = cmd.latch ? f_right  : cur_right_reg;
    assign v_parent = cmd.latch ? f_parent : cur_parent_reg;
    assign v_valid  = cmd.latch ? f_valid  : cur_valid_reg;
    assign child    = key_reg[0] ? v_right : v_left;

    // parent view with the freed child detached
    assign u_right = (v_right == prev_reg) ? '0 : v_right;
    assign u_left  = (v_right == prev_reg) ? v_left : '0;

    assign plen_clamped = (in_plen > PW'(KEY_BITS)) ? PW'(KEY_BITS) : in_plen;

    assign stat.req        = req_reg;
    assign stat.at_plen    = (i_reg == plen_reg);
    assign stat.last_step  = ((i_reg + PW'(1)) == plen_reg);
    assign stat.at_key_end = (i_reg == PW'(KEY_BITS));
    assign stat.child_zero = (child == '0);
    assign stat.cur_valid  = v_valid;
    assign stat.has_child  = (v_left != '0) || (v_right != '0);
    assign stat.node_zero  = node_is_root;
    assign stat.free_nz    = (free_head_reg != '0);
    assign stat.bump_ok    = (next_unused_reg < (IW+1)'(NODE_COUNT));
    assign stat.prune_stop = (u_left != '0) || (u_right != '0) || v_valid || node_is_root;
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        root_left_next   = root_left_reg;
        root_right_next  = root_right_reg;
        root_valid_next  = root_valid_reg;
        root_data_next   = root_data_reg;
        free_head_next   = free_head_reg;
        next_unused_next = next_unused_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        req_next         = req_reg;
        key_next         = key_reg;
        plen_next        = plen_reg;
        i_next           = i_reg;
        val_next         = val_reg;
        node_next        = node_reg;
        prev_next        = prev_reg;
        alloc_next       = alloc_reg;
        cur_left_next    = v_left;
        cur_right_next   = v_right;
        cur_parent_next  = v_parent;
        cur_valid_next   = v_valid;
        status_next      = status_reg;
        hit_next         = hit_reg;
        res_next         = res_reg;
        m_status_next    = m_status_reg;
        m_hit_next       = m_hit_reg;
        m_value_next     = m_value_reg;
        lk_we            = 1'b0;
        lk_waddr         = node_reg;
        lk_wdata         = {v_parent, v_right, v_left};
        vl_we            = 1'b0;
        vl_waddr         = node_reg;
        vl_wdata         = '0;
        rd_addr          = node_reg;

        // longest match so far on a lookup walk
        if (cmd.latch && req_reg == btpt_pkg::REQ_LOOKUP && f_valid) begin
            hit_next = 1'b1;
            res_next = f_data;
        end

        case (cmd.op)
            btpt_pkg::OP_LOAD: begin
                req_next    = in_req;
                key_next    = in_key;
                plen_next   = plen_clamped;
                val_next    = in_val[VW-1:0];
                i_next      = '0;
                node_next   = '0;
                hit_next    = 1'b0;
                res_next    = '0;
                status_next = btpt_pkg::ST_NF;
            end
            btpt_pkg::OP_FETCH: begin
                rd_addr = node_reg;
            end
            btpt_pkg::OP_DESCEND: begin
                node_next = child;
                i_next    = i_reg + PW'(1);
                key_next  = key_reg >> 1;
            end
            btpt_pkg::OP_STATUS: begin
                status_next = cmd.code;
            end
            btpt_pkg::OP_FIN: begin
                status_next = hit_next ? btpt_pkg::ST_OK : btpt_pkg::ST_NF;
            end
            btpt_pkg::OP_SETVAL: begin
                status_next = btpt_pkg::ST_OK;
                if (node_is_root) begin
                    root_valid_next = 1'b1;
                    root_data_next  = val_reg;
                end else begin
                    vl_we    = 1'b1;
                    vl_wdata = {1'b1, val_reg};
                end
            end
            btpt_pkg::OP_CLRVAL: begin
                status_next = btpt_pkg::ST_OK;
                if (node_is_root) begin
                    root_valid_next = 1'b0;
                    root_data_next  = '0;
                end else begin
                    vl_we    = 1'b1;
                    vl_wdata = '0;
                end
            end
            btpt_pkg::OP_FREE_RD: begin
                rd_addr = free_head_reg;
            end
            btpt_pkg::OP_TAKE_FR: begin
                alloc_next     = free_head_reg;
                free_head_next = lk_rdata[2*IW-1:IW];
            end
            btpt_pkg::OP_TAKE_BMP: begin
                alloc_next       = next_unused_reg[IW-1:0];
                next_unused_next = next_unused_reg + (IW+1)'(1);
            end
            btpt_pkg::OP_WR_NEW: begin
                lk_we    = 1'b1;
                lk_waddr = alloc_reg;
                lk_wdata = {node_reg, {IW{1'b0}}, {IW{1'b0}}};
                vl_we    = 1'b1;
                vl_waddr = alloc_reg;
                vl_wdata = '0;
            end
            btpt_pkg::OP_LINK: begin
                if (key_reg[0]) begin
                    lk_wdata = {v_parent, alloc_reg, v_left};
                end else begin
                    lk_wdata = {v_parent, v_right, alloc_reg};
                end
                if (node_is_root) begin
                    if (key_reg[0]) begin
                        root_right_next = alloc_reg;
                    end else begin
                        root_left_next = alloc_reg;
                    end
                end else begin
                    lk_we = 1'b1;
                end
                node_next       = alloc_reg;
                cur_left_next   = '0;
                cur_right_next  = '0;
                cur_parent_next = node_reg;
                cur_valid_next  = 1'b0;
                i_next          = i_reg + PW'(1);
                key_next        = key_reg >> 1;
            end
            btpt_pkg::OP_FREE: begin
                lk_we          = 1'b1;
                lk_wdata       = {v_parent, free_head_reg, v_left};
                vl_we          = 1'b1;
                vl_wdata       = '0;
                free_head_next = node_reg;
                prev_next      = node_reg;
                node_next      = v_parent;
            end
            btpt_pkg::OP_UNLINK: begin
                cur_left_next  = u_left;
                cur_right_next = u_right;
                lk_wdata       = {v_parent, u_right, u_left};
                if (node_is_root) begin
                    root_left_next  = u_left;
                    root_right_next = u_right;
                end else begin
                    lk_we = 1'b1;
                end
            end
            btpt_pkg::OP_OUT: begin
                m_tvalid_next = 1'b1;
                m_status_next = status_reg;
                m_hit_next    = hit_reg;
                m_value_next  = res_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_left_reg   <= '0;
            root_right_reg  <= '0;
            root_valid_reg  <= 1'b0;
            free_head_reg   <= '0;
            next_unused_reg <= (IW+1)'(1);
            m_tvalid_reg    <= 1'b0;
        end else begin
            root_left_reg   <= root_left_next;
            root_right_reg  <= root_right_next;
            root_valid_reg  <= root_valid_next;
            free_head_reg   <= free_head_next;
            next_unused_reg <= next_unused_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        root_data_reg  <= root_data_next;
        req_reg        <= req_next;
        key_reg        <= key_next;
        plen_reg       <= plen_next;
        i_reg          <= i_next;
        val_reg        <= val_next;
        node_reg       <= node_next;
        prev_reg       <= prev_next;
        alloc_reg      <= alloc_next;
        cur_left_reg   <= cur_left_next;
        cur_right_reg  <= cur_right_next;
        cur_parent_reg <= cur_parent_next;
        cur_valid_reg  <= cur_valid_next;
        status_reg     <= status_next;
        hit_reg        <= hit_next;
        res_reg        <= res_next;
        m_status_reg   <= m_status_next;
        m_hit_reg      <= m_hit_next;
        m_value_reg    <= m_value_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_status = m_status_reg;
    assign m_hit    = m_hit_reg;
    assign m_value  = btpt_pkg::VALIN_W'(m_value_reg);
endmodule

>>> rtl/core/binary_trie_prefix_table.sv
// Top level of the binary trie prefix table (insert, delete, longest prefix lookup).
`timescale 1ns / 1ps
// Usage:
//   The slave channel takes one request word: tuser carries the request kind
//   (insert, delete, lookup), tdata the key, prefix length and value. The
//   master channel returns one result word per request: tuser the status,
//   tdata the hit flag and the matched value.
//   One request is in flight at a time. Each trie level reads the node
//   memory (a registered read), then decides; a lookup descends at most
//   KEY_BITS levels. An insert allocates, writes and links each new node,
//   reading the free list first when it takes a node from it; a delete
//   frees, rereads and unlinks each node while pruning upward.
//   Reset empties the table at once: the root is held in flip-flops and other
//   nodes are written when allocated, so no clearing pass is needed.
//   The result sits in an output register; when the receiver stalls the
//   block holds it and waits before taking the next request.
module binary_trie_prefix_table #(
    parameter int NODE_COUNT = 1024,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // key [63:0], prefix_len [70:64], entry_value [102:71], zero pad [103]
    input  logic [btpt_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type [1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit [0], result_value [32:1], zero pad [39:33]
    output logic [btpt_pkg::M_TDATA_W-1:0]    m_tdata,
    // status [1:0]
    output logic [1:0]                        m_tuser
);
    `include "binary_trie_prefix_table_assert.svh"

    btpt_pkg::cmd_t  cmd;
    btpt_pkg::stat_t stat;
    logic            out_hit;
    logic [btpt_pkg::VALIN_W-1:0] out_value;

    // sequence each request through walk, allocate and prune phases
    btpt_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    // node memories, free list and result register
    btpt_dp #(
        .NODE_COUNT(NODE_COUNT), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .stat(stat),
        .in_req(s_tuser),
        .in_key(s_tdata[63:0]),
        .in_plen(s_tdata[70:64]),
        .in_val(s_tdata[102:71]),
        .m_tready(m_tready), .m_tvalid(m_tvalid),
        .m_status(m_tuser), .m_hit(out_hit), .m_value(out_value)
    );

    // pack the result word, zero fill the top
    assign m_tdata = {7'd0, out_value, out_hit};

    // a taken request blocks the next one until its result is loaded
    `BTPT_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second request taken")
    // the result register is only loaded when free
    `BTPT_ASSERT_IMP(a_out_free, cmd.op == btpt_pkg::OP_OUT, !m_tvalid || m_tready, "overwrite")
    // loading the result raises valid
    `BTPT_ASSERT_NXT(a_out_valid, cmd.op == btpt_pkg::OP_OUT, m_tvalid, "result lost")
endmodule
